// File: hw/rtl/character_tokenizer_macros.svh
// ----------------------------------------------------------------------------
// Character tokenizer assertion macros
// Concurrent property wrappers used by the top-level tokenizer module.
// ----------------------------------------------------------------------------
`ifndef CHARACTER_TOKENIZER_MACROS_SVH
`define CHARACTER_TOKENIZER_MACROS_SVH

// condition holding now implies consequence in the same cycle
`define CTOK_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// condition holding now implies consequence in the next cycle
`define CTOK_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// condition must never hold
`define CTOK_ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error(msg);

`endif

// File: hw/rtl/ctok_pkg.sv
// ----------------------------------------------------------------------------
// Character tokenizer package
// Shared types for the lexer core, the result queue and the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ctok_pkg;

   localparam int unsigned QUEUE_DEPTH = 4;

   localparam logic [2:0] KIND_NUMBER = 3'd0;
   localparam logic [2:0] KIND_IDENT  = 3'd1;
   localparam logic [2:0] KIND_STRING = 3'd2;
   localparam logic [2:0] KIND_SYMBOL = 3'd3;
   localparam logic [2:0] KIND_PAIR   = 3'd4;

   typedef enum logic [2:0] {
      MODE_IDLE  = 3'd0,
      MODE_NUM   = 3'd1,
      MODE_IDENT = 3'd2,
      MODE_OP    = 3'd3,
      MODE_STR   = 3'd4,
      MODE_ESC   = 3'd5
   } mode_type;

   typedef struct packed {
      logic [7:0] out_char;
      logic [2:0] token_kind;
      logic       first_in_token;
      logic       last_in_token;
      logic       empty_token;
      logic       unterminated;
      logic       last_in_run;
   } rsp_type;

   typedef struct packed {
      logic [1:0] cnt;
      rsp_type    r0;
      rsp_type    r1;
   } push_type;

endpackage

`default_nettype wire

// File: hw/rtl/ctok_lexer.sv
// ----------------------------------------------------------------------------
// Character tokenizer lexer core
// Mode and held-character state; turns one character into up to two results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ctok_lexer (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               accept,
   input  wire logic [7:0]         char_code,
   input  wire logic               end_of_line,
   output ctok_pkg::push_type      push
);

   ctok_pkg::mode_type mode_ff, mode_in;
   logic [7:0] held_char_ff, held_char_in;
   logic       held_valid_ff, held_valid_in;
   logic       held_first_ff, held_first_in;
   logic [2:0] held_kind_ff, held_kind_in;
   logic       quote_dbl_ff, quote_dbl_in;
   logic       dot_seen_ff, dot_seen_in;
   ctok_pkg::push_type res;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= "0") && (c <= "9");
   endfunction

   function automatic logic is_symbol(input logic [7:0] c);
      return c inside {"+", "-", "*", "/", "@", "=", ")", "(", "]", "[", "}", "{",
                       ".", ",", ":", ";", "?", ">", "<", "'", "\"", "&", "%",
                       "$", "#", "|", "_", "\\", " ", "\n", "!"};
   endfunction

   function automatic logic is_op_start(input logic [7:0] c);
      return c inside {"+", "-", "*", "/", "=", ">", "<", "&", "|"};
   endfunction

   function automatic logic is_pair(input logic [7:0] a, input logic [7:0] b);
      return {a, b} inside {"==", ">=", "<=", "++", "--", "&&", "||",
                            {"/", "*"}, {"*", "/"}, "->", "=>"};
   endfunction

   function automatic ctok_pkg::rsp_type mk(input logic [7:0] c, input logic [2:0] kind,
                                            input logic first, input logic last,
                                            input logic empty, input logic unterm);
      ctok_pkg::rsp_type r;
      r.out_char       = c;
      r.token_kind     = kind;
      r.first_in_token = first;
      r.last_in_token  = last;
      r.empty_token    = empty;
      r.unterminated   = unterm;
      r.last_in_run    = 1'b0;
      return r;
   endfunction

   function automatic ctok_pkg::push_type put(input ctok_pkg::push_type p,
                                              input ctok_pkg::rsp_type r);
      ctok_pkg::push_type q;
      q = p;
      if (p.cnt == 2'd0) begin
         q.r0 = r;
      end else if (p.cnt == 2'd1) begin
         q.r1 = r;
      end
      if (p.cnt != 2'd2) begin
         q.cnt = p.cnt + 2'd1;
      end
      return q;
   endfunction

   always_comb begin
      logic       start;
      logic [7:0] quote;
      res           = '0;
      start         = 1'b0;
      mode_in       = mode_ff;
      held_char_in  = held_char_ff;
      held_valid_in = held_valid_ff;
      held_first_in = held_first_ff;
      held_kind_in  = held_kind_ff;
      quote_dbl_in  = quote_dbl_ff;
      dot_seen_in   = dot_seen_ff;
      quote         = quote_dbl_ff ? 8'("\"") : 8'("'");

      case (mode_ff)
         ctok_pkg::MODE_NUM: begin
            if (is_digit(char_code) || (char_code == "." && !dot_seen_ff)) begin
               if (char_code == ".") dot_seen_in = 1'b1;
               if (held_valid_ff) begin
                  res = put(res, mk(held_char_ff, held_kind_ff, held_first_ff,
                                    1'b0, 1'b0, 1'b0));
               end
               held_char_in  = char_code;
               held_kind_in  = ctok_pkg::KIND_NUMBER;
               held_first_in = 1'b0;
               held_valid_in = 1'b1;
            end else if (char_code == "f") begin
               if (held_valid_ff) begin
                  res = put(res, mk(held_char_ff, held_kind_ff, held_first_ff,
                                    1'b0, 1'b0, 1'b0));
               end
               res = put(res, mk(char_code, ctok_pkg::KIND_NUMBER, 1'b0, 1'b1, 1'b0, 1'b0));
               held_valid_in = 1'b0;
               mode_in       = ctok_pkg::MODE_IDLE;
            end else begin
               if (held_valid_ff) begin
                  res = put(res, mk(held_char_ff, held_kind_ff, held_first_ff,
                                    1'b1, 1'b0, 1'b0));
               end
               held_valid_in = 1'b0;
               start         = 1'b1;
            end
         end
         ctok_pkg::MODE_IDENT: begin
            if (held_valid_ff) begin
               res = put(res, mk(held_char_ff, held_kind_ff, held_first_ff,
                                 is_symbol(char_code), 1'b0, 1'b0));
            end
            if (!is_symbol(char_code)) begin
               held_char_in  = char_code;
               held_kind_in  = ctok_pkg::KIND_IDENT;
               held_first_in = 1'b0;
               held_valid_in = 1'b1;
            end else begin
               held_valid_in = 1'b0;
               start         = 1'b1;
            end
         end
         ctok_pkg::MODE_OP: begin
            if (held_valid_ff && is_pair(held_char_ff, char_code)) begin
               res = put(res, mk(held_char_ff, ctok_pkg::KIND_PAIR, 1'b1, 1'b0, 1'b0, 1'b0));
               res = put(res, mk(char_code, ctok_pkg::KIND_PAIR, 1'b0, 1'b1, 1'b0, 1'b0));
               held_valid_in = 1'b0;
               mode_in       = ctok_pkg::MODE_IDLE;
            end else begin
               if (held_valid_ff) begin
                  res = put(res, mk(held_char_ff, held_kind_ff, held_first_ff,
                                    1'b1, 1'b0, 1'b0));
               end
               held_valid_in = 1'b0;
               start         = 1'b1;
            end
         end
         ctok_pkg::MODE_STR: begin
            if (char_code == quote) begin
               if (held_valid_ff) begin
                  res = put(res, mk(held_char_ff, held_kind_ff, held_first_ff,
                                    1'b1, 1'b0, 1'b0));
               end else begin
                  res = put(res, mk(8'd0, ctok_pkg::KIND_STRING, 1'b1, 1'b1, 1'b1, 1'b0));
               end
               held_valid_in = 1'b0;
               mode_in       = ctok_pkg::MODE_IDLE;
            end else begin
               if (held_valid_ff) begin
                  res = put(res, mk(held_char_ff, held_kind_ff, held_first_ff,
                                    1'b0, 1'b0, 1'b0));
               end
               held_char_in  = char_code;
               held_kind_in  = ctok_pkg::KIND_STRING;
               held_first_in = !held_valid_ff;
               held_valid_in = 1'b1;
               if (char_code == "\\") mode_in = ctok_pkg::MODE_ESC;
            end
         end
         ctok_pkg::MODE_ESC: begin
            if (held_valid_ff) begin
               res = put(res, mk(held_char_ff, held_kind_ff, held_first_ff,
                                 1'b0, 1'b0, 1'b0));
            end
            held_char_in  = char_code;
            held_kind_in  = ctok_pkg::KIND_STRING;
            held_first_in = !held_valid_ff;
            held_valid_in = 1'b1;
            mode_in       = ctok_pkg::MODE_STR;
         end
         default: begin
            held_valid_in = 1'b0;
            start         = 1'b1;
         end
      endcase

      if (start) begin
         mode_in = ctok_pkg::MODE_IDLE;
         if (char_code == " ") begin
            mode_in = ctok_pkg::MODE_IDLE;
         end else if (is_digit(char_code)) begin
            held_char_in  = char_code;
            held_kind_in  = ctok_pkg::KIND_NUMBER;
            held_first_in = 1'b1;
            held_valid_in = 1'b1;
            dot_seen_in   = 1'b0;
            mode_in       = ctok_pkg::MODE_NUM;
         end else if (!is_symbol(char_code)) begin
            held_char_in  = char_code;
            held_kind_in  = ctok_pkg::KIND_IDENT;
            held_first_in = 1'b1;
            held_valid_in = 1'b1;
            mode_in       = ctok_pkg::MODE_IDENT;
         end else if (is_op_start(char_code)) begin
            held_char_in  = char_code;
            held_kind_in  = ctok_pkg::KIND_SYMBOL;
            held_first_in = 1'b1;
            held_valid_in = 1'b1;
            mode_in       = ctok_pkg::MODE_OP;
         end else if (char_code == "'" || char_code == "\"") begin
            quote_dbl_in = (char_code == "\"");
            mode_in      = ctok_pkg::MODE_STR;
         end else begin
            res = put(res, mk(char_code, ctok_pkg::KIND_SYMBOL, 1'b1, 1'b1, 1'b0, 1'b0));
         end
      end

      // flush at end of line
      if (end_of_line) begin
         if (mode_in == ctok_pkg::MODE_STR || mode_in == ctok_pkg::MODE_ESC) begin
            if (held_valid_in) begin
               res = put(res, mk(held_char_in, ctok_pkg::KIND_STRING, held_first_in,
                                 1'b1, 1'b0, 1'b1));
            end else begin
               res = put(res, mk(8'd0, ctok_pkg::KIND_STRING, 1'b1, 1'b1, 1'b0, 1'b1));
            end
         end else if (held_valid_in) begin
            res = put(res, mk(held_char_in, held_kind_in, held_first_in,
                              1'b1, 1'b0, 1'b0));
         end
         held_valid_in = 1'b0;
         mode_in       = ctok_pkg::MODE_IDLE;
      end

      if (res.cnt == 2'd1) res.r0.last_in_run = 1'b1;
      if (res.cnt == 2'd2) res.r1.last_in_run = 1'b1;
   end

   always_comb begin
      push = res;
      if (!accept) push.cnt = 2'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= ctok_pkg::MODE_IDLE;
         held_char_ff  <= '0;
         held_valid_ff <= 1'b0;
         held_first_ff <= 1'b0;
         held_kind_ff  <= '0;
         quote_dbl_ff  <= 1'b0;
         dot_seen_ff   <= 1'b0;
      end else if (accept) begin
         mode_ff       <= mode_in;
         held_char_ff  <= held_char_in;
         held_valid_ff <= held_valid_in;
         held_first_ff <= held_first_in;
         held_kind_ff  <= held_kind_in;
         quote_dbl_ff  <= quote_dbl_in;
         dot_seen_ff   <= dot_seen_in;
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/ctok_queue.sv
// ----------------------------------------------------------------------------
// Character tokenizer result queue
// Small register queue: takes up to two results a cycle, gives one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ctok_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  ctok_pkg::push_type       push,
   input  wire logic                pop,
   output ctok_pkg::rsp_type        head,
   output logic [$clog2(ctok_pkg::QUEUE_DEPTH):0] level
);

   localparam int unsigned PW = $clog2(ctok_pkg::QUEUE_DEPTH);

   ctok_pkg::rsp_type entry_ff [ctok_pkg::QUEUE_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PW:0]   level_ff, level_in;
   logic [PW-1:0] wr_next;

   always_comb begin
      wr_next   = wr_ptr_ff + PW'(1);
      wr_ptr_in = wr_ptr_ff + PW'(push.cnt);
      rd_ptr_in = rd_ptr_ff + PW'(pop);
      level_in  = level_ff + (PW+1)'(push.cnt) - (PW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (push.cnt != 2'd0) entry_ff[wr_ptr_ff] <= push.r0;
      if (push.cnt == 2'd2) entry_ff[wr_next]   <= push.r1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   assign head  = entry_ff[rd_ptr_ff];
   assign level = level_ff;

endmodule

`default_nettype wire

// File: hw/rtl/character_tokenizer.sv
// ----------------------------------------------------------------------------
// Character tokenizer
// Splits a character stream into tagged token characters, one per result.
//
//   channel  dir  handshake             payload
//   req      in   req_tvalid/tready     tdata char_code, tlast end_of_line
//   rsp      out  rsp_tvalid/tready     tdata char + flags, tuser kind, tlast
//
// One character is accepted per cycle while req_tready is high; it gives zero,
// one or two results, which are written into a four-entry queue feeding rsp.
// The queue drains one result per cycle while rsp_tready is high, so a run of
// items each giving two results is held back by req_tready.
// req_tready drops while the queue cannot take two more results.
// Synchronous reset returns the lexer to idle and empties the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "character_tokenizer_macros.svh"

module character_tokenizer (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] char_code
   input  wire logic        req_tlast,   // end_of_line
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // [7:0] out_char, [8] first_in_token,
                                         // [9] last_in_token, [10] unterminated
   output logic [3:0]       rsp_tuser,   // [2:0] token_kind, [3] empty_token
   output logic             rsp_tlast    // last_in_run
);

   localparam int unsigned LW = $clog2(ctok_pkg::QUEUE_DEPTH) + 1;

   logic               accept;
   logic               pop;
   ctok_pkg::push_type push;
   ctok_pkg::rsp_type  head;
   logic [LW-1:0]      level;

   assign req_tready = (level <= LW'(ctok_pkg::QUEUE_DEPTH - 2));
   assign accept     = req_tvalid & req_tready;
   assign rsp_tvalid = (level != '0);
   assign pop        = rsp_tvalid & rsp_tready;

   ctok_lexer u_lexer (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .char_code   (req_tdata),
      .end_of_line (req_tlast),
      .push        (push)
   );

   ctok_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .head  (head),
      .level (level)
   );

   assign rsp_tdata = {5'd0, head.unterminated, head.last_in_token,
                       head.first_in_token, head.out_char};
   assign rsp_tuser = {head.empty_token, head.token_kind};
   assign rsp_tlast = head.last_in_run;

   `CTOK_ASSERT_NEVER(a_level_bound, clock, reset, level > LW'(ctok_pkg::QUEUE_DEPTH), "queue overflow")
   `CTOK_ASSERT_NEVER(a_push_on_accept, clock, reset, !accept && push.cnt != 2'd0, "push without transaction")
   `CTOK_ASSERT_IMPL(a_run_closed, clock, reset, push.cnt == 2'd1, push.r0.last_in_run, "run not closed")
   `CTOK_ASSERT_NEXT(a_drain, clock, reset, pop && level == LW'(1) && push.cnt == 2'd0, !rsp_tvalid, "queue not drained")

endmodule

`default_nettype wire

// File: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// Character tokenizer testbench
// Feeds character streams into the tokenizer and checks every token character against
// a cycle-free lexer written here, or a lit table row against its stored result. A
// short table of hand-picked characters comes first, then random lines built from
// numbers, identifiers, quoted strings, operator pairs, lone symbols, spaces and noise
// bytes. Both stream sides idle and stall at random, with calm stretches in between.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

   typedef struct packed {
      logic [7:0]        c;
      logic              eol;
      logic              lit;
      ctok_pkg::rsp_type want;
   } row_type;

   localparam ctok_pkg::rsp_type NO_RSP = '0;
   localparam int DIR_ROWS = 25;
   localparam int RANDOM_ITEMS = 600;

   localparam row_type DIRECTED [DIR_ROWS] = '{
      '{"(",   1'b1, 1'b1, '{"(", ctok_pkg::KIND_SYMBOL, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1}},
      '{"'",   1'b1, 1'b1, '{8'h00, ctok_pkg::KIND_STRING, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1}},
      '{"\"",  1'b0, 1'b0, NO_RSP},
      '{"\"",  1'b0, 1'b1, '{8'h00, ctok_pkg::KIND_STRING, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1}},
      '{"1",   1'b0, 1'b0, NO_RSP},
      '{".",   1'b0, 1'b0, NO_RSP},
      '{"2",   1'b0, 1'b0, NO_RSP},
      '{".",   1'b0, 1'b0, NO_RSP},
      '{"7",   1'b0, 1'b0, NO_RSP},
      '{"f",   1'b0, 1'b0, NO_RSP},
      '{"=",   1'b0, 1'b0, NO_RSP},
      '{"=",   1'b0, 1'b0, NO_RSP},
      '{"-",   1'b0, 1'b0, NO_RSP},
      '{">",   1'b0, 1'b0, NO_RSP},
      '{"<",   1'b1, 1'b1, '{"<", ctok_pkg::KIND_SYMBOL, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1}},
      '{"'",   1'b0, 1'b0, NO_RSP},
      '{"a",   1'b0, 1'b0, NO_RSP},
      '{"\\",  1'b0, 1'b0, NO_RSP},
      '{"'",   1'b0, 1'b0, NO_RSP},
      '{"'",   1'b0, 1'b0, NO_RSP},
      '{8'h0A, 1'b1, 1'b1, '{8'h0A, ctok_pkg::KIND_SYMBOL, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1}},
      '{8'hFF, 1'b0, 1'b0, NO_RSP},
      '{8'h00, 1'b0, 1'b0, NO_RSP},
      '{" ",   1'b0, 1'b0, NO_RSP},
      '{"\"",  1'b1, 1'b1, '{8'h00, ctok_pkg::KIND_STRING, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1}}
   };

   localparam logic [15:0] OP_PAIRS [11] = '{
      "==", ">=", "<=", "++", "--", "&&", "||", "/*", "*/", "->", "=>"
   };

   localparam string SYM_CHARS = "+-*/@=)(][}{.,:;?><&%$#|_!";

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;   // [7:0] char_code
   logic        req_tlast;   // end_of_line
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;   // [7:0] out_char, [8] first_in_token, [9] last_in_token,
                             // [10] unterminated
   logic [3:0]  rsp_tuser;   // [2:0] token_kind, [3] empty_token
   logic        rsp_tlast;   // last_in_run

   // lexer state
   ctok_pkg::mode_type lx_mode;
   logic [7:0]  hold_c;
   logic        hold_v;
   logic        hold_f;
   logic [2:0]  hold_k;
   logic        dq;
   logic        dot;

   ctok_pkg::rsp_type step_res[$];
   ctok_pkg::rsp_type token_q[$];
   logic [7:0]  line_q[$];
   int          err_count;
   logic        sender_calm;
   logic        recv_calm;

   character_tokenizer uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   function automatic logic is_digit(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic is_symbol(input logic [7:0] c);
      return c inside {"+", "-", "*", "/", "@", "=", ")", "(", "]", "[", "}", "{",
                       ".", ",", ":", ";", "?", ">", "<", "'", "\"", "&", "%", "$",
                       "#", "|", "_", "\\", " ", 8'h0A, "!"};
   endfunction

   function automatic void put_res(input logic [7:0] c, input logic [2:0] k,
                                   input logic f, input logic l, input logic em,
                                   input logic un);
      ctok_pkg::rsp_type r;
      r = '{c, k, f, l, em, un, 1'b0};
      if (step_res.size() < 2) step_res.push_back(r);
   endfunction

   function automatic void emit_held(input logic l);
      if (hold_v) put_res(hold_c, hold_k, hold_f, l, 1'b0, 1'b0);
      hold_v = 1'b0;
   endfunction

   function automatic void hold_char(input logic [7:0] c, input logic [2:0] k,
                                     input logic f);
      hold_c = c;
      hold_k = k;
      hold_f = f;
      hold_v = 1'b1;
   endfunction

   function automatic void open_token(input logic [7:0] c);
      lx_mode = ctok_pkg::MODE_IDLE;
      if (c == " ") begin
      end else if (is_digit(c)) begin
         hold_char(c, ctok_pkg::KIND_NUMBER, 1'b1);
         dot = 1'b0;
         lx_mode = ctok_pkg::MODE_NUM;
      end else if (!is_symbol(c)) begin
         hold_char(c, ctok_pkg::KIND_IDENT, 1'b1);
         lx_mode = ctok_pkg::MODE_IDENT;
      end else if (c inside {"+", "-", "*", "/", "=", ">", "<", "&", "|"}) begin
         hold_char(c, ctok_pkg::KIND_SYMBOL, 1'b1);
         lx_mode = ctok_pkg::MODE_OP;
      end else if (c == "'" || c == "\"") begin
         dq = (c == "\"");
         lx_mode = ctok_pkg::MODE_STR;
      end else begin
         put_res(c, ctok_pkg::KIND_SYMBOL, 1'b1, 1'b1, 1'b0, 1'b0);
      end
   endfunction

   // fill step_res with the token characters one input character releases
   function automatic void tokenize(input logic [7:0] c, input logic e);
      logic       f;
      logic       paired;
      logic [7:0] q;
      step_res.delete();
      case (lx_mode)
         ctok_pkg::MODE_NUM: begin
            if (is_digit(c) || (c == "." && !dot)) begin
               if (c == ".") dot = 1'b1;
               emit_held(1'b0);
               hold_char(c, ctok_pkg::KIND_NUMBER, 1'b0);
            end else if (c == "f") begin
               emit_held(1'b0);
               put_res(c, ctok_pkg::KIND_NUMBER, 1'b0, 1'b1, 1'b0, 1'b0);
               lx_mode = ctok_pkg::MODE_IDLE;
            end else begin
               emit_held(1'b1);
               open_token(c);
            end
         end
         ctok_pkg::MODE_IDENT: begin
            if (!is_symbol(c)) begin
               emit_held(1'b0);
               hold_char(c, ctok_pkg::KIND_IDENT, 1'b0);
            end else begin
               emit_held(1'b1);
               open_token(c);
            end
         end
         ctok_pkg::MODE_OP: begin
            paired = 1'b0;
            foreach (OP_PAIRS[i]) if (OP_PAIRS[i] == {hold_c, c}) paired = 1'b1;
            if (hold_v && paired) begin
               put_res(hold_c, ctok_pkg::KIND_PAIR, 1'b1, 1'b0, 1'b0, 1'b0);
               put_res(c, ctok_pkg::KIND_PAIR, 1'b0, 1'b1, 1'b0, 1'b0);
               hold_v = 1'b0;
               lx_mode = ctok_pkg::MODE_IDLE;
            end else begin
               emit_held(1'b1);
               open_token(c);
            end
         end
         ctok_pkg::MODE_STR: begin
            q = dq ? "\"" : "'";
            if (c == q) begin
               if (hold_v) emit_held(1'b1);
               else put_res(8'h00, ctok_pkg::KIND_STRING, 1'b1, 1'b1, 1'b1, 1'b0);
               lx_mode = ctok_pkg::MODE_IDLE;
            end else begin
               f = !hold_v;
               emit_held(1'b0);
               hold_char(c, ctok_pkg::KIND_STRING, f);
               if (c == "\\") lx_mode = ctok_pkg::MODE_ESC;
            end
         end
         ctok_pkg::MODE_ESC: begin
            f = !hold_v;
            emit_held(1'b0);
            hold_char(c, ctok_pkg::KIND_STRING, f);
            lx_mode = ctok_pkg::MODE_STR;
         end
         default: begin
            hold_v = 1'b0;
            open_token(c);
         end
      endcase
      if (e) begin
         if (lx_mode == ctok_pkg::MODE_STR || lx_mode == ctok_pkg::MODE_ESC) begin
            if (hold_v) put_res(hold_c, ctok_pkg::KIND_STRING, hold_f, 1'b1, 1'b0, 1'b1);
            else put_res(8'h00, ctok_pkg::KIND_STRING, 1'b1, 1'b1, 1'b0, 1'b1);
            hold_v = 1'b0;
         end else begin
            emit_held(1'b1);
         end
         lx_mode = ctok_pkg::MODE_IDLE;
      end
      if (step_res.size() > 0) step_res[step_res.size() - 1].last_in_run = 1'b1;
   endfunction

   function automatic logic [7:0] plain_char();
      logic [7:0] c;
      if ($urandom_range(0, 1) == 0) return 8'(("a" + $urandom_range(0, 25)));
      do c = 8'($urandom_range(0, 255)); while (is_symbol(c) || is_digit(c));
      return c;
   endfunction

   function automatic void add_token();
      logic [7:0]  q;
      logic [15:0] p;
      case ($urandom_range(0, 9))
         0, 1: begin
            repeat ($urandom_range(1, 3)) line_q.push_back(8'("0" + $urandom_range(0, 9)));
            if ($urandom_range(0, 1) == 0) begin
               line_q.push_back(".");
               repeat ($urandom_range(0, 2)) line_q.push_back(8'("0" + $urandom_range(0, 9)));
               if ($urandom_range(0, 3) == 0) line_q.push_back(".");
            end
            if ($urandom_range(0, 2) == 0) line_q.push_back("f");
         end
         2, 3: begin
            line_q.push_back(plain_char());
            repeat ($urandom_range(0, 5)) begin
               if ($urandom_range(0, 3) == 0) line_q.push_back(8'("0" + $urandom_range(0, 9)));
               else line_q.push_back(plain_char());
            end
         end
         4, 5: begin
            q = ($urandom_range(0, 1) == 0) ? "'" : "\"";
            line_q.push_back(q);
            repeat ($urandom_range(0, 5)) begin
               if ($urandom_range(0, 4) == 0) begin
                  line_q.push_back("\\");
                  line_q.push_back(($urandom_range(0, 1) == 0) ? q : 8'($urandom_range(0, 255)));
               end else if ($urandom_range(0, 5) == 0) begin
                  line_q.push_back(" ");
               end else begin
                  line_q.push_back(plain_char());
               end
            end
            if ($urandom_range(0, 7) != 0) line_q.push_back(q);
         end
         6: begin
            p = OP_PAIRS[$urandom_range(0, 10)];
            line_q.push_back(p[15:8]);
            line_q.push_back(p[7:0]);
         end
         7: line_q.push_back(8'(SYM_CHARS[$urandom_range(0, SYM_CHARS.len() - 1)]));
         8: line_q.push_back(($urandom_range(0, 3) == 0) ? 8'h0A : 8'(" "));
         default: line_q.push_back(8'($urandom_range(0, 255)));
      endcase
   endfunction

   task automatic send_char(input logic [7:0] c, input logic e, input logic lit,
                            input ctok_pkg::rsp_type want);
      int gap;
      gap = sender_calm ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      req_tlast  <= e;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      tokenize(c, e);
      if (lit) token_q.push_back(want);
      else foreach (step_res[i]) token_q.push_back(step_res[i]);
   endtask

   task automatic drain_tokens();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (token_q.size() != 0) @(posedge clock);
   endtask

   task automatic check_field(input string name, input logic [7:0] want,
                              input logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected 'h%0h, got 'h%0h", name, want, got);
         err_count++;
      end
   endtask

   always @(posedge clock) begin
      ctok_pkg::rsp_type got;
      ctok_pkg::rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '{rsp_tdata[7:0], rsp_tuser[2:0], rsp_tdata[8], rsp_tdata[9],
                 rsp_tuser[3], rsp_tdata[10], rsp_tlast};
         if (token_q.size() == 0) begin
            $error("transaction with nothing pending: out_char 'h%0h", got.out_char);
            err_count++;
         end else begin
            want = token_q.pop_front();
            check_field("out_char", want.out_char, got.out_char);
            check_field("token_kind", 8'(want.token_kind), 8'(got.token_kind));
            check_field("first_in_token", 8'(want.first_in_token), 8'(got.first_in_token));
            check_field("last_in_token", 8'(want.last_in_token), 8'(got.last_in_token));
            check_field("empty_token", 8'(want.empty_token), 8'(got.empty_token));
            check_field("unterminated", 8'(want.unterminated), 8'(got.unterminated));
            check_field("last_in_run", 8'(want.last_in_run), 8'(got.last_in_run));
         end
      end
   end

   // result side back-pressure
   initial begin
      int gap;
      rsp_tready = 1'b0;
      recv_calm  = 1'b0;
      forever begin
         if ($urandom_range(0, 30) == 0) recv_calm = !recv_calm;
         gap = recv_calm ? 0 : $urandom_range(0, 12);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
      end
   end

   initial begin
      #2000000;
      $display("tb_top: done, errors");
      $finish;
   end

   initial begin
      int sent;
      int lines;
      int eol_at;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = 8'h00;
      req_tlast   = 1'b0;
      sender_calm = 1'b0;
      err_count   = 0;
      lx_mode     = ctok_pkg::MODE_IDLE;
      hold_c      = 8'h00;
      hold_v      = 1'b0;
      hold_f      = 1'b0;
      hold_k      = ctok_pkg::KIND_NUMBER;
      dq          = 1'b0;
      dot         = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIR_ROWS; i++)
         send_char(DIRECTED[i].c, DIRECTED[i].eol, DIRECTED[i].lit, DIRECTED[i].want);

      // hold the sender until the pipeline is empty
      drain_tokens();

      sent  = 0;
      lines = 0;
      while (sent < RANDOM_ITEMS) begin
         line_q.delete();
         repeat ($urandom_range(1, 8)) add_token();
         sender_calm = ($urandom_range(0, 4) == 0);
         eol_at = ($urandom_range(0, 5) == 0) ? $urandom_range(0, line_q.size() - 1) : -1;
         foreach (line_q[i])
            send_char(line_q[i], (i == line_q.size() - 1) || (i == eol_at), 1'b0, NO_RSP);
         sent += line_q.size();
         lines++;
         if (lines == 12) drain_tokens();
      end

      drain_tokens();
      repeat (10) @(posedge clock);
      if (err_count == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

endmodule
